>>> hdl/mcdd_pkg.sv
// shared types, constants and segment table of the clock display driver
`default_nettype none
package mcdd_pkg;

    localparam int unsigned PATTERN_W = 11;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned ENABLE_W  = 4;

    localparam logic [COUNT_W-1:0] REFRESH_RELOAD = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 8'd1;

    localparam logic [PATTERN_W-1:0] BLANK_WORD = 11'h7D8;

    localparam logic [1:0] DIGIT_HOURS_TENS   = 2'd0;
    localparam logic [1:0] DIGIT_HOURS_ONES   = 2'd1;
    localparam logic [1:0] DIGIT_MINUTES_TENS = 2'd2;
    localparam logic [1:0] DIGIT_MINUTES_ONES = 2'd3;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    localparam logic [0:0] REG_BRIGHTNESS = 1'b0;

    typedef struct packed {
        logic [DIGIT_W-1:0] hours_tens;
        logic               hours_tens_ok;
        logic [DIGIT_W-1:0] hours_ones;
        logic [DIGIT_W-1:0] minutes_tens;
        logic               minutes_tens_ok;
        logic [DIGIT_W-1:0] minutes_ones;
    } split_t;

    // active-low segment word per digit value
    function automatic logic [PATTERN_W-1:0] seg_word(input logic [DIGIT_W-1:0] d);
        logic [PATTERN_W-1:0] w;
        begin
            case (d)
                4'd0:    w = 11'h400;
                4'd1:    w = 11'h658;
                4'd2:    w = 11'h0C0;
                4'd3:    w = 11'h048;
                4'd4:    w = 11'h218;
                4'd5:    w = 11'h108;
                4'd6:    w = 11'h100;
                4'd7:    w = 11'h458;
                4'd8:    w = 11'h000;
                4'd9:    w = 11'h008;
                default: w = BLANK_WORD;
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/mcdd_digit_split.sv
// splits hour and minute into tens and ones digits
`default_nettype none
module mcdd_digit_split
    import mcdd_pkg::*;
(
    input  wire logic [7:0] hour,
    input  wire logic [7:0] minute,
    output split_t          split
);

    logic [15:0] hour_prod;
    logic [15:0] minute_prod;
    logic [4:0]  hour_q;
    logic [4:0]  minute_q;
    logic [7:0]  hour_r;
    logic [7:0]  minute_r;

    // divide by ten as multiply by 205 and shift by 11, exact below 1029
    always_comb
    begin
        hour_prod   = 16'({8'd0, hour} * 16'd205);
        minute_prod = 16'({8'd0, minute} * 16'd205);
        hour_q      = hour_prod[15:11];
        minute_q    = minute_prod[15:11];
        hour_r      = hour - 8'({3'd0, hour_q} * 8'd10);
        minute_r    = minute - 8'({3'd0, minute_q} * 8'd10);

        split.hours_tens      = hour_q[3:0];
        split.hours_tens_ok   = (hour_q <= 5'd9);
        split.hours_ones      = hour_r[3:0];
        split.minutes_tens    = minute_q[3:0];
        split.minutes_tens_ok = (minute_q <= 5'd9);
        split.minutes_ones    = minute_r[3:0];
    end

endmodule
`default_nettype wire

>>> hdl/mcdd_scan.sv
// refresh counter, digit store and segment/enable registers
`default_nettype none
module mcdd_scan
    import mcdd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 func,
    input  wire split_t               split,
    input  wire logic [COUNT_W-1:0]   threshold,
    output logic [PATTERN_W-1:0]      segment_pattern,
    output logic [ENABLE_W-1:0]       digit_enable
);

    logic [COUNT_W-1:0]   count_reg,        count_next;
    logic [1:0]           index_reg,        index_next;
    logic [DIGIT_W-1:0]   hours_tens_reg,   hours_tens_next;
    logic [DIGIT_W-1:0]   hours_ones_reg,   hours_ones_next;
    logic [DIGIT_W-1:0]   minutes_tens_reg, minutes_tens_next;
    logic [DIGIT_W-1:0]   minutes_ones_reg, minutes_ones_next;
    logic [PATTERN_W-1:0] pattern_reg,      pattern_next;
    logic [ENABLE_W-1:0]  enable_reg,       enable_next;
    logic [PATTERN_W-1:0] digit_word;

    always_comb
    begin
        unique case (index_reg)
            DIGIT_HOURS_TENS:
            begin
                digit_word = (hours_tens_reg == '0) ? BLANK_WORD : seg_word(hours_tens_reg);
            end
            DIGIT_HOURS_ONES:   digit_word = seg_word(hours_ones_reg);
            DIGIT_MINUTES_TENS: digit_word = seg_word(minutes_tens_reg);
            DIGIT_MINUTES_ONES: digit_word = seg_word(minutes_ones_reg);
            default:            digit_word = BLANK_WORD;
        endcase
    end

    always_comb
    begin
        count_next        = count_reg;
        index_next        = index_reg;
        hours_tens_next   = hours_tens_reg;
        hours_ones_next   = hours_ones_reg;
        minutes_tens_next = minutes_tens_reg;
        minutes_ones_next = minutes_ones_reg;
        pattern_next      = pattern_reg;
        enable_next       = enable_reg;
        if (load)
        begin
            if (func == FUNC_TICK)
            begin
                // pwm dimming on the count before decrement
                if (count_reg < threshold)
                begin
                    enable_next = '0;
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    count_next   = REFRESH_RELOAD;
                    pattern_next = digit_word;
                    enable_next  = ENABLE_W'(1) << index_reg;
                    index_next   = index_reg + 1'b1;
                end
            end
            else
            begin
                if (split.hours_tens_ok)
                begin
                    hours_tens_next = split.hours_tens;
                end
                hours_ones_next = split.hours_ones;
                if (split.minutes_tens_ok)
                begin
                    minutes_tens_next = split.minutes_tens;
                end
                minutes_ones_next = split.minutes_ones;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= COUNT_RESET;
            index_reg        <= DIGIT_HOURS_TENS;
            hours_tens_reg   <= 4'd0;
            hours_ones_reg   <= 4'd1;
            minutes_tens_reg <= 4'd2;
            minutes_ones_reg <= 4'd3;
            pattern_reg      <= '0;
            enable_reg       <= '0;
        end
        else
        begin
            count_reg        <= count_next;
            index_reg        <= index_next;
            hours_tens_reg   <= hours_tens_next;
            hours_ones_reg   <= hours_ones_next;
            minutes_tens_reg <= minutes_tens_next;
            minutes_ones_reg <= minutes_ones_next;
            pattern_reg      <= pattern_next;
            enable_reg       <= enable_next;
        end
    end

    assign segment_pattern = pattern_reg;
    assign digit_enable    = enable_reg;

`ifndef SYNTHESIS
    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(enable_reg))
        else $error("digit enable not one-hot");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= REFRESH_RELOAD)
        else $error("refresh count above reload");

    a_reload_enables: assert property (@(posedge clk) disable iff (!rst_n)
        (load && func == FUNC_TICK && count_reg == '0)
        |=> (enable_reg == (ENABLE_W'(1) << $past(index_reg)) && count_reg == REFRESH_RELOAD))
        else $error("digit reload did not enable next digit");

    a_set_keeps_output: assert property (@(posedge clk) disable iff (!rst_n)
        (load && func == FUNC_SET) |=> ($stable(pattern_reg) && $stable(enable_reg)))
        else $error("set-time transaction changed display drive");
`endif

endmodule
`default_nettype wire

>>> hdl/multiplexed_clock_display_driver.sv
// top level: apb brightness register, transaction handshake and display scan
`default_nettype none
// Four-digit HH:MM seven-segment driver. Every input transaction gives one
// result transaction: a tick (func 0) steps the refresh counter, clears the
// enable while the count is below brightness and, when it passes zero,
// latches the next digit's active-low segment word and one-hot enable; a
// set-time transaction (func 1) loads new digits and returns the current drive
// unchanged. A transaction is accepted whenever the result register is empty
// or being taken in the same cycle, so one can enter every cycle while results
// are taken; out_valid is registered. Brightness is an APB register at offset 0.
module multiplexed_clock_display_driver
    import mcdd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 func,
    input  wire logic [7:0]           hour,
    input  wire logic [7:0]           minute,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PATTERN_W-1:0]      segment_pattern,
    output logic [ENABLE_W-1:0]       digit_enable
);

    logic [COUNT_W-1:0] bright_reg, bright_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               cfg_write;
    split_t             split;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        bright_next = bright_reg;
        if (cfg_write && paddr[2] == REG_BRIGHTNESS)
        begin
            bright_next = pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BRIGHTNESS: prdata = {{(32-COUNT_W){1'b0}}, bright_reg};
            default:        prdata = '0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bright_reg    <= bright_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    mcdd_digit_split u_split (
        .hour   (hour),
        .minute (minute),
        .split  (split)
    );

    mcdd_scan u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (accept),
        .func            (func),
        .split           (split),
        .threshold       (bright_reg),
        .segment_pattern (segment_pattern),
        .digit_enable    (digit_enable)
    );

endmodule
`default_nettype wire
